@@ rtl/core/cia_pkg.sv @@
// shared types for the checked integer alu
// opcode and status codes plus the control word carried down the pipeline
package cia_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_POS_OVF  = 2'd1,
      ST_NEG_OVF  = 2'd2,
      ST_DIV_ZERO = 2'd3
   } status_type;

   typedef struct packed {
      op_type     op;
      logic       neg;
      logic       early;
      status_type status;
   } ctl_type;

endpackage

@@ rtl/core/cia_prep.sv @@
// operand decode stage: add/sub with overflow, magnitudes, divide special cases
// depends on cia_pkg
module cia_prep #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [1:0]                opcode,
   input  logic [DATA_WIDTH-1:0]     operand_a,
   input  logic [DATA_WIDTH-1:0]     operand_b,
   output logic                      out_valid,
   output cia_pkg::ctl_type          out_ctl,
   output logic [DATA_WIDTH-1:0]     out_x,
   output logic [DATA_WIDTH-1:0]     out_y,
   output logic [2*DATA_WIDTH-1:0]   out_acc
);
   import cia_pkg::*;

   localparam logic [DATA_WIDTH-1:0] MIN_VALUE = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic                    valid_ff;
   ctl_type                 ctl_ff, ctl_in;
   logic [DATA_WIDTH-1:0]   x_ff, x_in;
   logic [DATA_WIDTH-1:0]   y_ff, y_in;
   logic [2*DATA_WIDTH-1:0] acc_ff, acc_in;

   always_comb begin
      logic                  sign_a;
      logic                  sign_b;
      logic [DATA_WIDTH-1:0] sum;
      logic [DATA_WIDTH-1:0] diff;
      logic [DATA_WIDTH-1:0] res;
      sign_a = operand_a[DATA_WIDTH-1];
      sign_b = operand_b[DATA_WIDTH-1];
      sum    = operand_a + operand_b;
      diff   = operand_a - operand_b;
      res    = '0;
      ctl_in.op     = op_type'(opcode);
      ctl_in.neg    = sign_a ^ sign_b;
      ctl_in.early  = 1'b0;
      ctl_in.status = ST_OK;
      x_in = sign_a ? (~operand_a + 1'b1) : operand_a;
      y_in = sign_b ? (~operand_b + 1'b1) : operand_b;
      case (op_type'(opcode))
         OP_ADD: begin
            ctl_in.early = 1'b1;
            if (sign_a == sign_b && sum[DATA_WIDTH-1] != sign_a) begin
               ctl_in.status = sign_a ? ST_NEG_OVF : ST_POS_OVF;
            end else begin
               res = sum;
            end
         end
         OP_SUB: begin
            ctl_in.early = 1'b1;
            if (sign_a != sign_b && diff[DATA_WIDTH-1] != sign_a) begin
               ctl_in.status = sign_a ? ST_NEG_OVF : ST_POS_OVF;
            end else begin
               res = diff;
            end
         end
         OP_DIV: begin
            if (operand_b == '0) begin
               ctl_in.early  = 1'b1;
               ctl_in.status = ST_DIV_ZERO;
            end else if (operand_a == MIN_VALUE && operand_b == '1) begin
               ctl_in.early  = 1'b1;
               ctl_in.status = ST_POS_OVF;
            end
         end
         default: begin
         end
      endcase
      acc_in = {{DATA_WIDTH{1'b0}}, res};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= ctl_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_acc   = acc_ff;

endmodule

@@ rtl/core/cia_bit_stage.sv @@
// one bit step of the shared multiply / divide pipeline
// multiply: shift-add of one multiplier bit; divide: one restoring quotient bit; uses cia_pkg
module cia_bit_stage #(
   parameter int DATA_WIDTH = 32,
   parameter int BIT_INDEX  = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  cia_pkg::ctl_type          in_ctl,
   input  logic [DATA_WIDTH-1:0]     in_x,
   input  logic [DATA_WIDTH-1:0]     in_y,
   input  logic [2*DATA_WIDTH-1:0]   in_acc,
   output logic                      out_valid,
   output cia_pkg::ctl_type          out_ctl,
   output logic [DATA_WIDTH-1:0]     out_x,
   output logic [DATA_WIDTH-1:0]     out_y,
   output logic [2*DATA_WIDTH-1:0]   out_acc
);
   import cia_pkg::*;

   logic                    valid_ff;
   ctl_type                 ctl_ff;
   logic [DATA_WIDTH-1:0]   x_ff, x_in;
   logic [DATA_WIDTH-1:0]   y_ff;
   logic [2*DATA_WIDTH-1:0] acc_ff, acc_in;

   always_comb begin
      logic [2*DATA_WIDTH-1:0] partial;
      logic [DATA_WIDTH:0]     part_rem;
      logic [DATA_WIDTH:0]     trial;
      logic                    take;
      partial  = {{DATA_WIDTH{1'b0}}, in_x} << BIT_INDEX;
      part_rem = {in_acc[DATA_WIDTH-1:0], in_x[DATA_WIDTH-1]};
      trial    = part_rem - {1'b0, in_y};
      take     = ~trial[DATA_WIDTH];
      x_in     = in_x;
      acc_in   = in_acc;
      if (!in_ctl.early) begin
         case (in_ctl.op)
            OP_MUL: begin
               if (in_y[BIT_INDEX]) begin
                  acc_in = in_acc + partial;
               end
            end
            OP_DIV: begin
               x_in   = {in_x[DATA_WIDTH-2:0], take};
               acc_in = {{DATA_WIDTH{1'b0}},
                         take ? trial[DATA_WIDTH-1:0] : part_rem[DATA_WIDTH-1:0]};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= in_ctl;
         x_ff   <= x_in;
         y_ff   <= in_y;
         acc_ff <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_acc   = acc_ff;

endmodule

@@ rtl/core/cia_finish.sv @@
// final sign fix and multiply range check
// combinational, feeds the output buffer; uses cia_pkg
module cia_finish #(
   parameter int DATA_WIDTH = 32
) (
   input  cia_pkg::ctl_type          in_ctl,
   input  logic [DATA_WIDTH-1:0]     in_x,
   input  logic [2*DATA_WIDTH-1:0]   in_acc,
   output logic [DATA_WIDTH-1:0]     result,
   output cia_pkg::status_type       status
);
   import cia_pkg::*;

   always_comb begin
      logic [DATA_WIDTH-1:0] high_part;
      logic [DATA_WIDTH-1:0] low_part;
      logic [DATA_WIDTH-1:0] limit;
      high_part = in_acc[2*DATA_WIDTH-1:DATA_WIDTH];
      low_part  = in_acc[DATA_WIDTH-1:0];
      limit     = {in_ctl.neg, {(DATA_WIDTH-1){~in_ctl.neg}}};
      result    = '0;
      status    = in_ctl.status;
      if (in_ctl.early) begin
         result = low_part;
      end else begin
         case (in_ctl.op)
            OP_MUL: begin
               if (high_part != '0 || low_part > limit) begin
                  status = in_ctl.neg ? ST_NEG_OVF : ST_POS_OVF;
               end else begin
                  result = in_ctl.neg ? (~low_part + 1'b1) : low_part;
               end
            end
            OP_DIV: begin
               result = in_ctl.neg ? (~in_x + 1'b1) : in_x;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

@@ rtl/core/cia_skid.sv @@
// two-entry output buffer: output register plus skid register
// ready toward the pipeline is registered; no package dependency
module cia_skid #(
   parameter int WIDTH = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             main_valid_ff, main_valid_in;
   logic [WIDTH-1:0] main_data_ff, main_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;

   always_comb begin
      logic in_fire;
      logic out_fire;
      in_fire       = in_valid && !skid_valid_ff;
      out_fire      = main_valid_ff && out_ready;
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || out_fire) begin
         main_valid_in = skid_valid_ff || in_fire;
         main_data_in  = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

@@ rtl/core/checked_int_alu_unit.sv @@
// checked signed integer alu: add, subtract, multiply, divide with overflow status
// top level; uses cia_pkg, cia_prep, cia_bit_stage, cia_finish, cia_skid
//
// req channel carries one operation per transaction: tuser is the opcode
// (add, subtract, multiply, divide), tdata holds operand_a in the low
// DATA_WIDTH bits and operand_b above it. rsp channel returns one transaction
// per request, in order: tdata is the result, tuser the status (ok, positive
// overflow, negative overflow, divide by zero); the result is zero on error.
// every operation goes through the same pipeline: a decode register, then
// DATA_WIDTH bit stages (one multiplier bit or one quotient bit each), then
// the output register. one transaction is accepted per cycle while
// req_tready is high. when rsp_tready is low the output register holds and
// the skid register takes the next result; after that the whole pipeline
// holds and req_tready drops (it comes from a register). reset empties the
// pipeline and the output buffer.
module checked_int_alu_unit #(
   parameter int DATA_WIDTH = 32,
   localparam int REQ_DATA_BITS = ((2 * DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // operand_a, operand_b
   input  logic [1:0]               req_tuser,   // opcode
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // result
   output logic [1:0]               rsp_tuser    // status
);
   import cia_pkg::*;

   logic                    pipe_en;
   logic                    stage_valid [DATA_WIDTH+1];
   ctl_type                 stage_ctl   [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0]   stage_x     [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0]   stage_y     [DATA_WIDTH+1];
   logic [2*DATA_WIDTH-1:0] stage_acc   [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0]   fin_result;
   status_type              fin_status;
   logic [DATA_WIDTH+1:0]   out_data;

   cia_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_tvalid),
      .opcode    (req_tuser),
      .operand_a (req_tdata[DATA_WIDTH-1:0]),
      .operand_b (req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .out_valid (stage_valid[0]),
      .out_ctl   (stage_ctl[0]),
      .out_x     (stage_x[0]),
      .out_y     (stage_y[0]),
      .out_acc   (stage_acc[0])
   );

   for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_bit
      cia_bit_stage #(.DATA_WIDTH(DATA_WIDTH), .BIT_INDEX(k)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (stage_valid[k]),
         .in_ctl    (stage_ctl[k]),
         .in_x      (stage_x[k]),
         .in_y      (stage_y[k]),
         .in_acc    (stage_acc[k]),
         .out_valid (stage_valid[k+1]),
         .out_ctl   (stage_ctl[k+1]),
         .out_x     (stage_x[k+1]),
         .out_y     (stage_y[k+1]),
         .out_acc   (stage_acc[k+1])
      );
   end

   cia_finish #(.DATA_WIDTH(DATA_WIDTH)) u_finish (
      .in_ctl (stage_ctl[DATA_WIDTH]),
      .in_x   (stage_x[DATA_WIDTH]),
      .in_acc (stage_acc[DATA_WIDTH]),
      .result (fin_result),
      .status (fin_status)
   );

   cia_skid #(.WIDTH(DATA_WIDTH + 2)) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[DATA_WIDTH]),
      .in_ready  (pipe_en),
      .in_data   ({fin_status, fin_result}),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign req_tready = pipe_en;
   assign rsp_tdata  = RSP_DATA_BITS'(out_data[DATA_WIDTH-1:0]);
   assign rsp_tuser  = out_data[DATA_WIDTH+1:DATA_WIDTH];

   // error transactions carry a zero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_type'(rsp_tuser) != ST_OK |-> rsp_tdata == '0)
      else $error("nonzero result with error status");

   // the skid register only fills behind a held output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("pipeline stalled with empty output register");

   // a stalled pipeline keeps its last stage
   assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(stage_valid[DATA_WIDTH]))
      else $error("last pipeline stage changed during stall");

endmodule

@@ tb/sv/checked_int_alu_checker.sv @@
// result checker for checked_int_alu_unit: watches the req and rsp channels,
// predicts each response from the accepted operation and compares in order
// depends on cia_pkg for the opcode and status codes
module checked_int_alu_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // operand_a, operand_b
   input  logic [1:0]  req_tuser,   // opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // result
   input  logic [1:0]  rsp_tuser,   // status
   output int          fail_count,
   output int          outstanding,
   output int          checked_count,
   output int          fault_count
);
   import cia_pkg::*;

   localparam longint WORD_MAX = (longint'(1) <<< 31) - 1;
   localparam longint WORD_MIN = -(longint'(1) <<< 31);

   typedef struct packed {
      logic [31:0] result;
      status_type  status;
   } alu_outcome_type;

   alu_outcome_type expected_results[$];
   alu_outcome_type next_expected;

   function automatic alu_outcome_type checked_result(op_type op, logic signed [31:0] a,
                                                      logic signed [31:0] b);
      longint exact;
      alu_outcome_type r;
      r.result = '0;
      r.status = ST_OK;
      exact = 0;
      case (op)
         OP_ADD: exact = longint'(a) + longint'(b);
         OP_SUB: exact = longint'(a) - longint'(b);
         OP_MUL: exact = longint'(a) * longint'(b);
         OP_DIV: begin
            if (b == 0) begin
               r.status = ST_DIV_ZERO;
               return r;
            end
            // truncating divide; smallest value by minus one lands above the range
            exact = longint'(a) / longint'(b);
         end
         default: exact = 0;
      endcase
      if (exact > WORD_MAX) begin
         r.status = ST_POS_OVF;
      end else if (exact < WORD_MIN) begin
         r.status = ST_NEG_OVF;
      end else begin
         r.result = exact[31:0];
      end
      return r;
   endfunction

   task automatic record_mismatch(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch: %s", what);
      end
   endtask

   initial begin
      fail_count = 0;
      outstanding = 0;
      checked_count = 0;
      fault_count = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(checked_result(op_type'(req_tuser),
                                                      req_tdata[31:0], req_tdata[63:32]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               record_mismatch($sformatf("unexpected rsp transaction: result %0d status %0d",
                                         $signed(rsp_tdata), rsp_tuser));
            end else begin
               next_expected = expected_results.pop_front();
               checked_count++;
               if (next_expected.status != ST_OK) begin
                  fault_count++;
               end
               if (rsp_tdata !== next_expected.result || rsp_tuser !== next_expected.status) begin
                  record_mismatch($sformatf("rsp %0d: expected result %0d status %s, got %0d %0d",
                                            checked_count, $signed(next_expected.result),
                                            next_expected.status.name(),
                                            $signed(rsp_tdata), rsp_tuser));
               end
            end
         end
         outstanding = expected_results.size();
      end
   end

endmodule

@@ tb/sv/checked_int_alu_unit_tb.sv @@
// testbench top for checked_int_alu_unit: drives boundary and random operations
// with random idling and back-pressure, gives the verdict
// depends on cia_pkg, checked_int_alu_unit and checked_int_alu_checker
module checked_int_alu_unit_tb;
   import cia_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 150;
   localparam logic [31:0] WORD_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
   localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // operand_a, operand_b
   logic [1:0]  req_tuser;   // opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // result
   logic [1:0]  rsp_tuser;   // status

   int fail_count;
   int outstanding;
   int checked_count;
   int fault_count;
   int sent_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit tx_idle_on = 1'b0;
   bit rx_idle_on = 1'b0;
   bit hold_req = 1'b0;

   checked_int_alu_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   checked_int_alu_checker alu_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .fault_count   (fault_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("checked_int_alu_unit_tb: FAIL");
         $finish;
      end
   end

   // mostly no gap, some short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5: v = $urandom_range(0, 200) - 100;
         6: begin
            case ($urandom_range(0, 4))
               0: v = WORD_MAX;
               1: v = WORD_MIN;
               2: v = MINUS_ONE;
               3: v = 32'd1;
               default: v = '0;
            endcase
         end
         // around the square root of the range, where products cross the edge
         7: v = $urandom_range(46338, 46343);
         8: v = 32'd1 << $urandom_range(0, 31);
         default: v = {{16{1'b0}}, 16'($urandom)};
      endcase
      if ($urandom_range(0, 1) && (v inside {[32'd1 : WORD_MAX]})) begin
         v = -v;
      end
      return v;
   endfunction

   task automatic send_op(input op_type op, input logic [31:0] a, input logic [31:0] b);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      gap = tx_idle_on ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata <= {$urandom, $urandom};
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_ops(input int count);
      repeat (count) begin
         send_op(op_type'($urandom_range(0, 3)), pick_operand(), pick_operand());
      end
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = rx_idle_on ? idle_len() : 0;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_ADD;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // boundary cases
      send_op(OP_ADD, WORD_MAX, 32'd1);
      send_op(OP_ADD, WORD_MIN, MINUS_ONE);
      send_op(OP_ADD, WORD_MAX, WORD_MIN);
      send_op(OP_ADD, '0, '0);
      send_op(OP_SUB, WORD_MIN, 32'd1);
      send_op(OP_SUB, WORD_MAX, MINUS_ONE);
      send_op(OP_SUB, '0, WORD_MIN);
      send_op(OP_SUB, MINUS_ONE, WORD_MAX);
      send_op(OP_MUL, WORD_MAX, WORD_MAX);
      send_op(OP_MUL, WORD_MIN, WORD_MIN);
      send_op(OP_MUL, WORD_MIN, MINUS_ONE);
      send_op(OP_MUL, WORD_MIN, 32'd1);
      send_op(OP_MUL, WORD_MIN, '0);
      send_op(OP_MUL, '0, WORD_MAX);
      send_op(OP_MUL, 32'd46341, 32'd46341);
      send_op(OP_MUL, -32'sd46341, 32'd46341);
      send_op(OP_MUL, 32'd65536, -32'sd32768);
      send_op(OP_MUL, 32'd65536, 32'd32768);
      send_op(OP_DIV, 32'd5, '0);
      send_op(OP_DIV, WORD_MIN, '0);
      send_op(OP_DIV, WORD_MIN, MINUS_ONE);
      send_op(OP_DIV, -32'sd7, 32'd2);
      send_op(OP_DIV, 32'd7, -32'sd2);
      send_op(OP_DIV, WORD_MIN, 32'd1);
      send_op(OP_DIV, WORD_MAX, MINUS_ONE);
      pause_until_drained();

      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send_random_ops(400);

      // output held off while the sender keeps offering
      tx_idle_on = 1'b0;
      hold_req = 1'b1;
      send_random_ops(100);

      rx_idle_on = 1'b0;
      send_random_ops(300);
      pause_until_drained();

      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send_random_ops(500);

      pause_until_drained();
      repeat (40) @(posedge clock);
      $display("sent %0d operations: boundary cases, then random mixes with idling, "
               , sent_count, "full-rate bursts and a long output hold-off");
      $display("compared %0d results, %0d of them with overflow or divide-by-zero status",
               checked_count, fault_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("checked_int_alu_unit_tb: PASS");
      end else begin
         $display("checked_int_alu_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/cia_pkg.sv
rtl/core/cia_prep.sv
rtl/core/cia_bit_stage.sv
rtl/core/cia_finish.sv
rtl/core/cia_skid.sv
rtl/core/checked_int_alu_unit.sv
tb/sv/checked_int_alu_checker.sv
tb/sv/checked_int_alu_unit_tb.sv
